// ===== src/pressure_temperature_compensation_macros.svh =====
// Assertion macros shared by the compensation pipeline.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
// Plain property check, off while reset is high.
`define PTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// A frozen pipe keeps the given signal as it is.
`define PTC_ASSERT_STALL(lbl, sig, msg) \
   `PTC_ASSERT(lbl, !reset && !en |=> $stable(sig), msg)
`else
`define PTC_ASSERT(lbl, prop, msg)
`define PTC_ASSERT_STALL(lbl, sig, msg)
`endif
`endif

// ===== src/ptc_pkg.sv =====
// Shared types and constants of the pressure/temperature compensation pipeline.
package ptc_pkg;

   localparam int FINE_W = 25;   // fine temperature, signed
   localparam int QUOT_W = 37;   // quotient bits out of the divider
   localparam int DEN_W  = 39;   // divisor magnitude
   localparam int NUM_W  = 74;   // dividend magnitude (numerator times 3125)

   localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
   localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
   localparam logic [24:0]        PRESS_MAX = 25'h1FF_FFFF;
   localparam logic signed [24:0] FINE_OFS  = 25'sd128000;

   typedef enum logic [1:0] {
      CSR_CAL_TEMP    = 2'd0,
      CSR_CAL_PRESS_A = 2'd1,
      CSR_CAL_PRESS_B = 2'd2,
      CSR_CAL_PRESS_C = 2'd3
   } ptc_csr_type;

   // calibration words, raw bits; signedness applied at use
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } ptc_cal_type;

   // per-item info that rides alongside the divider
   typedef struct packed {
      logic [14:0] temp;
      logic        neg;
      logic        invalid;
   } ptc_side_type;

endpackage

// ===== src/ptc_front.sv =====
// Fine temperature: three pipeline stages.
module ptc_front import ptc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [19:0]              raw_pressure,
   input  logic [19:0]              raw_temperature,
   input  ptc_cal_type              cal,
   output logic                     out_valid,
   output logic signed [FINE_W-1:0] fine,
   output logic [19:0]              out_raw_pressure
);

   logic signed [17:0] t_diff;
   logic signed [16:0] dt;
   logic signed [33:0] aprod_in, aprod_ff, dtsq_in, dtsq_ff;
   logic signed [22:0] a_in, a_ff;
   logic signed [21:0] dsh;
   logic signed [37:0] bprod_in, bprod_ff;
   logic signed [FINE_W-1:0] fine_in, fine_ff;
   logic [19:0] adcp1_ff, adcp2_ff, adcp3_ff;
   logic v1_ff, v2_ff, v3_ff;

   always_comb begin
      t_diff   = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
      dt       = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
      aprod_in = t_diff * $signed(cal.t2);
      dtsq_in  = dt * dt;
      a_in     = 23'(aprod_ff >>> 11);
      dsh      = 22'(dtsq_ff >>> 12);
      bprod_in = dsh * $signed(cal.t3);
      fine_in  = FINE_W'(a_ff) + FINE_W'(bprod_ff >>> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aprod_ff <= aprod_in;
         dtsq_ff  <= dtsq_in;
         adcp1_ff <= raw_pressure;
         a_ff     <= a_in;
         bprod_ff <= bprod_in;
         adcp2_ff <= adcp1_ff;
         fine_ff  <= fine_in;
         adcp3_ff <= adcp2_ff;
      end
   end

   assign out_valid        = v3_ff;
   assign fine             = fine_ff;
   assign out_raw_pressure = adcp3_ff;

endmodule

// ===== src/ptc_poly.sv =====
// Temperature result, divisor and dividend polynomials: seven pipeline stages.
module ptc_poly import ptc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [FINE_W-1:0] fine,
   input  logic [19:0]              raw_pressure,
   input  ptc_cal_type              cal,
   output logic                     out_valid,
   output logic [NUM_W-1:0]         num,
   output logic [DEN_W-1:0]         den,
   output ptc_side_type             side
);

   // stage 4
   logic signed [FINE_W-1:0] x;
   logic signed [49:0] xx_full;
   logic signed [47:0] xx_ff;
   logic signed [40:0] xp5_in, xp5_4_ff, xp5_5_ff, xp2_in, xp2_4_ff, xp2_5_ff;
   logic signed [27:0] t5;
   logic signed [19:0] tsh;
   logic [14:0] temp_in;
   // stage 5
   logic signed [63:0] x2p6_in, x2p6_ff, x2p3_in, x2p3_ff;
   // stage 6
   logic signed [63:0] y_in, y_ff, a2;
   logic signed [55:0] v_in, v_ff;
   // stage 7
   logic [20:0] p_off;
   logic signed [63:0] num_in, num_ff;
   logic signed [40:0] hp_in, hp_ff;
   logic [47:0] lp_in, lp_ff;
   // stage 8
   logic signed [40:0] dsum;
   logic signed [39:0] div_in, div_ff;
   logic [62:0] nmag_in, nmag_ff;
   logic nneg_ff;
   // stages 9 and 10
   logic [DEN_W-1:0] dmag_in, dmag9_ff, dmag10_ff;
   logic [NUM_W-1:0] shi_in, shi_ff, slo_in, slo_ff, n_ff;
   ptc_side_type side9_in, side9_ff, side10_ff;

   logic [14:0] temp4_ff, temp5_ff, temp6_ff, temp7_ff, temp8_ff;
   logic [19:0] adcp4_ff, adcp5_ff, adcp6_ff;
   logic [6:0]  vld_ff;

   always_comb begin
      x       = fine - FINE_OFS;
      xx_full = x * x;
      xp5_in  = x * $signed(cal.p5);
      xp2_in  = x * $signed(cal.p2);
      t5      = 28'(fine) * 28'sd5 + 28'sd128;
      tsh     = 20'(t5 >>> 8);
      if (tsh < 20'(TEMP_MIN)) begin
         temp_in = TEMP_MIN;
      end else if (tsh > 20'(TEMP_MAX)) begin
         temp_in = TEMP_MAX;
      end else begin
         temp_in = tsh[14:0];
      end

      x2p6_in = xx_ff * $signed(cal.p6);
      x2p3_in = xx_ff * $signed(cal.p3);

      y_in = x2p6_ff + (64'(xp5_5_ff) <<< 17) + (64'($signed(cal.p4)) <<< 35);
      a2   = (x2p3_ff >>> 8) + (64'(xp2_5_ff) <<< 12);
      v_in = 56'(a2 + 64'sd140737488355328);

      p_off  = 21'd1048576 - {1'b0, adcp6_ff};
      num_in = $signed({12'd0, p_off, 31'd0}) - y_ff;
      hp_in  = $signed(v_ff[55:32]) * $signed({1'b0, cal.p1});
      lp_in  = v_ff[31:0] * cal.p1;

      // floor(v * p1 / 2^33) from the two partial products
      dsum    = hp_ff + $signed({25'd0, lp_ff[47:32]});
      div_in  = 40'(dsum >>> 1);
      nmag_in = num_ff[63] ? 63'(-num_ff) : num_ff[62:0];

      dmag_in          = div_ff[39] ? 39'(-div_ff) : div_ff[38:0];
      side9_in.temp    = temp8_ff;
      side9_in.neg     = nneg_ff ^ div_ff[39];
      side9_in.invalid = (div_ff == '0);
      // times 3125 = 2048 + 1024 + 32 + 16 + 4 + 1
      shi_in = (NUM_W'(nmag_ff) << 11) + (NUM_W'(nmag_ff) << 10) + (NUM_W'(nmag_ff) << 5);
      slo_in = (NUM_W'(nmag_ff) << 4) + (NUM_W'(nmag_ff) << 2) + NUM_W'(nmag_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff     <= xx_full[47:0];
         xp5_4_ff  <= xp5_in;
         xp2_4_ff  <= xp2_in;
         temp4_ff  <= temp_in;
         adcp4_ff  <= raw_pressure;

         x2p6_ff   <= x2p6_in;
         x2p3_ff   <= x2p3_in;
         xp5_5_ff  <= xp5_4_ff;
         xp2_5_ff  <= xp2_4_ff;
         temp5_ff  <= temp4_ff;
         adcp5_ff  <= adcp4_ff;

         y_ff      <= y_in;
         v_ff      <= v_in;
         temp6_ff  <= temp5_ff;
         adcp6_ff  <= adcp5_ff;

         num_ff    <= num_in;
         hp_ff     <= hp_in;
         lp_ff     <= lp_in;
         temp7_ff  <= temp6_ff;

         div_ff    <= div_in;
         nmag_ff   <= nmag_in;
         nneg_ff   <= num_ff[63];
         temp8_ff  <= temp7_ff;

         dmag9_ff  <= dmag_in;
         shi_ff    <= shi_in;
         slo_ff    <= slo_in;
         side9_ff  <= side9_in;

         n_ff      <= shi_ff + slo_ff;
         dmag10_ff <= dmag9_ff;
         side10_ff <= side9_ff;
      end
   end

   assign out_valid = vld_ff[6];
   assign num       = n_ff;
   assign den       = dmag10_ff;
   assign side      = side10_ff;

endmodule

// ===== src/ptc_div.sv =====
// Pipelined restoring divider: range check stage, then one quotient bit per stage.
`include "pressure_temperature_compensation_macros.svh"
module ptc_div import ptc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  ptc_side_type      in_side,
   output logic              out_valid,
   output logic [QUOT_W-1:0] quot,
   output logic              ovf,
   output ptc_side_type      out_side
);

   logic [DEN_W-1:0]  rem_ff  [0:QUOT_W];
   logic [DEN_W-1:0]  den_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] low_ff  [0:QUOT_W];
   logic [QUOT_W-1:0] q_ff    [0:QUOT_W];
   ptc_side_type      side_ff [0:QUOT_W];
   logic [QUOT_W:0]   ovf_ff;
   logic [QUOT_W:0]   vld_ff;

   logic [DEN_W:0]   trial [0:QUOT_W-1];
   logic             take  [0:QUOT_W-1];
   logic [DEN_W-1:0] rem_in [0:QUOT_W-1];
   logic [DEN_W-1:0] top;

   always_comb begin
      top = DEN_W'(num[NUM_W-1:QUOT_W]);
      for (int k = 0; k < QUOT_W; k++) begin
         trial[k]  = {rem_ff[k], low_ff[k][QUOT_W-1]};
         take[k]   = trial[k] >= {1'b0, den_ff[k]};
         rem_in[k] = take[k] ? DEN_W'(trial[k] - {1'b0, den_ff[k]}) : trial[k][DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[QUOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // quotient needs more than QUOT_W bits: saturate later
         rem_ff[0]  <= top;
         den_ff[0]  <= den;
         low_ff[0]  <= num[QUOT_W-1:0];
         q_ff[0]    <= '0;
         side_ff[0] <= in_side;
         ovf_ff[0]  <= top >= den;
         for (int k = 0; k < QUOT_W; k++) begin
            rem_ff[k+1]  <= rem_in[k];
            den_ff[k+1]  <= den_ff[k];
            low_ff[k+1]  <= low_ff[k] << 1;
            q_ff[k+1]    <= {q_ff[k][QUOT_W-2:0], take[k]};
            side_ff[k+1] <= side_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W];
   assign quot      = q_ff[QUOT_W];
   assign ovf       = ovf_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];

   `PTC_ASSERT_STALL(a_div_stall_holds, vld_ff, "divider valid bits moved while stalled")

endmodule

// ===== src/ptc_post.sv =====
// Quotient saturation, second-order correction and output register: four stages.
module ptc_post import ptc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [QUOT_W-1:0] quot,
   input  logic              ovf,
   input  ptc_side_type      side,
   input  ptc_cal_type       cal,
   output logic              out_valid,
   output logic [14:0]       temp,
   output logic [24:0]       press,
   output logic              invalid
);

   localparam logic [QUOT_W-1:0] LIM_POS = {1'b0, {(QUOT_W-1){1'b1}}};
   localparam logic [QUOT_W-1:0] LIM_NEG = {1'b1, {(QUOT_W-1){1'b0}}};

   logic [QUOT_W-1:0] lim, mag;
   logic signed [QUOT_W-1:0] q_in, q1_ff, q2_ff, q3_ff;
   logic signed [23:0] qs;
   logic signed [47:0] qsq_in, qsq_ff;
   logic signed [52:0] p8q_in, p8q_ff;
   logic signed [63:0] pq9_in, pq9_ff;
   logic signed [33:0] b_in, b_ff;
   logic signed [39:0] s;
   logic signed [32:0] pr;
   logic [24:0] press_in;
   ptc_side_type side1_ff, side2_ff, side3_ff;
   logic [2:0] vld_ff;
   logic out_valid_ff, invalid_ff;
   logic [14:0] temp_ff;
   logic [24:0] press_ff;

   always_comb begin
      lim  = side.neg ? LIM_NEG : LIM_POS;
      mag  = (ovf || (quot > lim)) ? lim : quot;
      q_in = side.neg ? $signed(QUOT_W'(-mag)) : $signed(mag);

      qs     = 24'(q1_ff >>> 13);
      qsq_in = qs * qs;
      p8q_in = q1_ff * $signed(cal.p8);

      pq9_in = qsq_ff * $signed(cal.p9);
      b_in   = 34'(p8q_ff >>> 19);

      s  = 40'(q3_ff) + 40'(pq9_ff >>> 25) + 40'(b_ff);
      pr = 33'(s >>> 8) + (33'($signed(cal.p7)) <<< 4);
      if (side3_ff.invalid || pr < 33'sd0) begin
         press_in = '0;
      end else if (pr > $signed({8'd0, PRESS_MAX})) begin
         press_in = PRESS_MAX;
      end else begin
         press_in = pr[24:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[1:0], in_valid};
         out_valid_ff <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_ff      <= q_in;
         side1_ff   <= side;
         qsq_ff     <= qsq_in;
         p8q_ff     <= p8q_in;
         q2_ff      <= q1_ff;
         side2_ff   <= side1_ff;
         pq9_ff     <= pq9_in;
         b_ff       <= b_in;
         q3_ff      <= q2_ff;
         side3_ff   <= side2_ff;
         temp_ff    <= side3_ff.temp;
         press_ff   <= press_in;
         invalid_ff <= side3_ff.invalid;
      end
   end

   assign out_valid = out_valid_ff;
   assign temp      = temp_ff;
   assign press     = press_ff;
   assign invalid   = invalid_ff;

endmodule

// ===== src/pressure_temperature_compensation.sv =====
// Top level: barometric pressure and temperature compensation pipeline.
//
// Use: write the four calibration registers through csr_we/csr_index/csr_wdata
// while no item is in flight (index 0 temperature words, 1..3 pressure words).
// Then send raw pressure/temperature pairs on req_valid/req_ready; each item
// yields exactly one result on rsp_valid/rsp_ready: temperature in 0.01 degC
// (saturated -4000..8500), pressure in Pa Q17.8 (saturated), and an invalid
// flag when the pressure divisor came out zero (pressure then reads 0).
// The 37 quotient bits of the pressure division take one pipeline stage each,
// which sets most of the pipeline depth.
// Throughput: one item per cycle while the receiver takes results.
// Stall: when rsp_valid is high and rsp_ready low the whole pipe freezes and
// req_ready drops; nothing is lost or repeated, bubbles are kept as is.
// Reset (synchronous, active high) clears calibration to zero and all valid
// bits; the block is ready the cycle after reset drops.
`include "pressure_temperature_compensation_macros.svh"
module pressure_temperature_compensation import ptc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [19:0]        req_raw_pressure,
   input  logic [19:0]        req_raw_temperature,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [24:0]        rsp_pressure_q8,
   output logic               rsp_pressure_invalid,
   // calibration writes
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_press_a_ff, cal_press_b_ff;
   logic [15:0] cal_press_c_ff;
   ptc_cal_type cal;

   logic en;
   logic front_valid, poly_valid, div_valid;
   logic signed [FINE_W-1:0] fine;
   logic [19:0] front_adcp;
   logic [NUM_W-1:0] num;
   logic [DEN_W-1:0] den;
   ptc_side_type poly_side, div_side;
   logic [QUOT_W-1:0] quot;
   logic ovf;
   logic [14:0] temp;

   // calibration register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
      end else if (csr_we) begin
         unique case (ptc_csr_type'(csr_index))
            CSR_CAL_TEMP:    cal_temp_ff    <= csr_wdata[47:0];
            CSR_CAL_PRESS_A: cal_press_a_ff <= csr_wdata;
            CSR_CAL_PRESS_B: cal_press_b_ff <= csr_wdata;
            CSR_CAL_PRESS_C: cal_press_c_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cal.t1 = cal_temp_ff[15:0];
   assign cal.t2 = cal_temp_ff[31:16];
   assign cal.t3 = cal_temp_ff[47:32];
   assign cal.p1 = cal_press_a_ff[15:0];
   assign cal.p2 = cal_press_a_ff[31:16];
   assign cal.p3 = cal_press_a_ff[47:32];
   assign cal.p4 = cal_press_a_ff[63:48];
   assign cal.p5 = cal_press_b_ff[15:0];
   assign cal.p6 = cal_press_b_ff[31:16];
   assign cal.p7 = cal_press_b_ff[47:32];
   assign cal.p8 = cal_press_b_ff[63:48];
   assign cal.p9 = cal_press_c_ff;

   // whole pipe advances unless a finished item is held at the output
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   ptc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_valid         (req_valid),
      .raw_pressure     (req_raw_pressure),
      .raw_temperature  (req_raw_temperature),
      .cal              (cal),
      .out_valid        (front_valid),
      .fine             (fine),
      .out_raw_pressure (front_adcp)
   );

   ptc_poly u_poly (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (front_valid),
      .fine         (fine),
      .raw_pressure (front_adcp),
      .cal          (cal),
      .out_valid    (poly_valid),
      .num          (num),
      .den          (den),
      .side         (poly_side)
   );

   ptc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (poly_valid),
      .num       (num),
      .den       (den),
      .in_side   (poly_side),
      .out_valid (div_valid),
      .quot      (quot),
      .ovf       (ovf),
      .out_side  (div_side)
   );

   ptc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .quot      (quot),
      .ovf       (ovf),
      .side      (div_side),
      .cal       (cal),
      .out_valid (rsp_valid),
      .temp      (temp),
      .press     (rsp_pressure_q8),
      .invalid   (rsp_pressure_invalid)
   );

   assign rsp_temperature_centi = $signed(temp);

   `PTC_ASSERT(a_invalid_zero, rsp_valid && rsp_pressure_invalid |-> rsp_pressure_q8 == '0, "invalid item with nonzero pressure")
   `PTC_ASSERT(a_temp_range, rsp_valid |-> (rsp_temperature_centi >= TEMP_MIN && rsp_temperature_centi <= TEMP_MAX), "temperature out of range")
   `PTC_ASSERT(a_stall_blocks_input, rsp_valid && !rsp_ready |-> !req_ready, "input taken while output held")

endmodule

// ===== verif/pressure_temperature_compensation_tb.sv =====
// Self-checking testbench for the pressure/temperature compensation pipeline.
`timescale 1ns / 100ps
module pressure_temperature_compensation_tb;
   import ptc_pkg::*;

   // wide signed math: every intermediate of the compensation fits easily
   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
   } sample_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [24:0]        pressure_q8;
      logic               pressure_invalid;
   } reading_type;

   localparam int PIPE_DEPTH = 52;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [19:0]        req_raw_pressure;
   logic [19:0]        req_raw_temperature;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [14:0] rsp_temperature_centi;
   logic [24:0]        rsp_pressure_q8;
   logic               rsp_pressure_invalid;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [63:0]        csr_wdata;

   pressure_temperature_compensation dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_raw_pressure      (req_raw_pressure),
      .req_raw_temperature   (req_raw_temperature),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q8       (rsp_pressure_q8),
      .rsp_pressure_invalid  (rsp_pressure_invalid),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // calibration as the testbench believes the block holds it
   logic [47:0] cal_temp_q;
   logic [63:0] cal_press_a_q;
   logic [63:0] cal_press_b_q;
   logic [15:0] cal_press_c_q;

   sample_type  samples_to_send[$];
   reading_type expected_readings[$];
   int          error_count;
   int          readings_checked;
   int          invalid_seen;
   int          temp_clamped_seen;
   bit          req_taken;         // item accepted at the last rising edge

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout: %0d readings still pending", expected_readings.size());
      $display("FAILURE");
      $finish;
   end

   // Compensation predictor: temperature first, then pressure from the
   // fine temperature of the same sample.
   function automatic reading_type compensate(sample_type s);
      wide_type    adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      wide_type    a, b, dt, fine, temp, x, y, den, num, n, d, mag, lim, q, qs, press;
      logic        neg;
      reading_type r;
      adc_p = s.raw_pressure;
      adc_t = s.raw_temperature;
      t1 = cal_temp_q[15:0];
      t2 = $signed(cal_temp_q[31:16]);
      t3 = $signed(cal_temp_q[47:32]);
      p1 = cal_press_a_q[15:0];
      p2 = $signed(cal_press_a_q[31:16]);
      p3 = $signed(cal_press_a_q[47:32]);
      p4 = $signed(cal_press_a_q[63:48]);
      p5 = $signed(cal_press_b_q[15:0]);
      p6 = $signed(cal_press_b_q[31:16]);
      p7 = $signed(cal_press_b_q[47:32]);
      p8 = $signed(cal_press_b_q[63:48]);
      p9 = $signed(cal_press_c_q);

      a    = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
      dt   = (adc_t >>> 4) - t1;
      b    = (((dt * dt) >>> 12) * t3) >>> 14;
      fine = a + b;
      temp = (fine * 5 + 128) >>> 8;
      if (temp < -4000) temp = -4000;
      if (temp > 8500) temp = 8500;
      r.temperature_centi = temp[14:0];

      x   = fine - 128000;
      y   = x * x * p6 + x * p5 * 131072 + (p4 <<< 35);
      a   = ((x * x * p3) >>> 8) + x * p2 * 4096;
      den = (((wide_type'(1) <<< 47) + a) * p1) >>> 33;
      if (den == 0) begin
         r.pressure_q8      = '0;
         r.pressure_invalid = 1'b1;
      end else begin
         num = (1048576 - adc_p) * (wide_type'(1) <<< 31) - y;
         neg = (num < 0) != (den < 0);
         n   = (num < 0) ? -num : num;
         d   = (den < 0) ? -den : den;
         mag = (n * 3125) / d;          // truncation toward zero
         lim = neg ? (wide_type'(1) <<< 36) : (wide_type'(1) <<< 36) - 1;
         if (mag > lim) mag = lim;
         q     = neg ? -mag : mag;
         qs    = q >>> 13;
         a     = (p9 * qs * qs) >>> 25;
         b     = (p8 * q) >>> 19;
         press = ((q + a + b) >>> 8) + p7 * 16;
         if (press < 0) press = 0;
         if (press > 33554431) press = 33554431;
         r.pressure_q8      = press[24:0];
         r.pressure_invalid = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      reading_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            expected_readings.push_back(
               compensate('{req_raw_pressure, req_raw_temperature}));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $display("unexpected result item at %0t", $realtime);
               error_count++;
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (want.pressure_invalid) invalid_seen++;
               if (want.temperature_centi == TEMP_MIN || want.temperature_centi == TEMP_MAX)
                  temp_clamped_seen++;
               if (rsp_temperature_centi !== want.temperature_centi)
                  report_mismatch("temperature_centi", rsp_temperature_centi,
                                  want.temperature_centi);
               if (rsp_pressure_q8 !== want.pressure_q8)
                  report_mismatch("pressure_q8", rsp_pressure_q8, want.pressure_q8);
               if (rsp_pressure_invalid !== want.pressure_invalid)
                  report_mismatch("pressure_invalid", rsp_pressure_invalid,
                                  want.pressure_invalid);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Driver: bursts of items with random gaps; changes at falling edge.
   // ---------------------------------------------------------------
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      sample_type s;
      logic       next_valid;
      if (reset) begin
         burst_left = 0;
         gap_left   = 0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (samples_to_send.size() > 0) begin
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            s = samples_to_send.pop_front();
            next_valid = 1'b1;
            req_raw_pressure    <= s.raw_pressure;
            req_raw_temperature <= s.raw_temperature;
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: stall pattern changes every so often; some stretches never stall.
   logic [15:0] stall_pattern;
   int          pattern_age;
   always @(negedge clock) begin
      if (reset) begin
         stall_pattern = 16'hFFFF;
         pattern_age   = 0;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0: stall_pattern = 16'hFFFF;
               1: stall_pattern = 16'($urandom);
               2: stall_pattern = 16'h00FF;
               default: stall_pattern = 16'($urandom) | 16'($urandom);
            endcase
         end
         pattern_age--;
         stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      end
      rsp_ready <= stall_pattern[0] | reset;
   end

   // ---------------------------------------------------------------
   // Calibration writes and stimulus phases
   // ---------------------------------------------------------------
   task automatic write_cal(ptc_csr_type idx, logic [63:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CAL_TEMP:    cal_temp_q    = value[47:0];
         CSR_CAL_PRESS_A: cal_press_a_q = value;
         CSR_CAL_PRESS_B: cal_press_b_q = value;
         default:         cal_press_c_q = value[15:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_cal(logic [47:0] ct, logic [63:0] pa, logic [63:0] pb,
                           logic [15:0] pc);
      write_cal(CSR_CAL_TEMP, {16'h0, ct});
      write_cal(CSR_CAL_PRESS_A, pa);
      write_cal(CSR_CAL_PRESS_B, pb);
      write_cal(CSR_CAL_PRESS_C, {48'h0, pc});
   endtask

   task automatic wait_drained();
      while (samples_to_send.size() > 0 || req_valid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
   endtask

   task automatic queue_directed();
      samples_to_send.push_back('{20'h0, 20'h0});
      samples_to_send.push_back('{20'hFFFFF, 20'hFFFFF});
      samples_to_send.push_back('{20'h0, 20'hFFFFF});
      samples_to_send.push_back('{20'hFFFFF, 20'h0});
      samples_to_send.push_back('{20'd415148, 20'd519888});
      samples_to_send.push_back('{20'hAAAAA, 20'h55555});
      samples_to_send.push_back('{20'h55555, 20'hAAAAA});
      samples_to_send.push_back('{20'h80000, 20'h80000});
      samples_to_send.push_back('{20'd300000, 20'd400000});
      samples_to_send.push_back('{20'd600000, 20'd600000});
   endtask

   task automatic queue_random(int count);
      repeat (count) begin
         if ($urandom_range(0, 2) == 0)
            samples_to_send.push_back('{20'($urandom), 20'($urandom)});
         else  // realistic operating region
            samples_to_send.push_back('{20'($urandom_range(200000, 700000)),
                                        20'($urandom_range(380000, 620000))});
      end
   endtask

   // typical datasheet-style calibration
   localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_PA = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_PB = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [15:0] TYP_PC = 16'd6000;

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_raw_pressure    = '0;
      req_raw_temperature = '0;
      rsp_ready   = 1'b1;
      csr_we      = 1'b0;
      csr_index   = CSR_CAL_TEMP;
      csr_wdata   = '0;
      error_count = 0;
      readings_checked  = 0;
      invalid_seen      = 0;
      temp_clamped_seen = 0;
      cal_temp_q    = '0;
      cal_press_a_q = '0;
      cal_press_b_q = '0;
      cal_press_c_q = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset calibration: every divisor is zero, so every item is flagged
      queue_directed();
      queue_random(60);
      wait_drained();

      load_cal(TYP_T, TYP_PA, TYP_PB, TYP_PC);
      queue_directed();
      queue_random(400);
      wait_drained();

      // all ones: largest unsigned words, -1 signed words
      load_cal('1, '1, '1, '1);
      queue_directed();
      queue_random(200);
      wait_drained();

      // smallest nonzero divisor scale drives the quotient into saturation
      load_cal({16'h7FFF, 16'h7FFF, 16'd1}, {16'h8000, 16'h7FFF, 16'h8000, 16'd1},
               {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
      queue_directed();
      queue_random(200);
      wait_drained();

      // strongly negative offsets push pressure below zero
      load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
               {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h7FFF);
      queue_directed();
      queue_random(200);
      wait_drained();

      // random calibrations, a few near typical and a few fully random
      repeat (6) begin
         if ($urandom_range(0, 1) == 0)
            load_cal(TYP_T ^ 48'($urandom_range(0, 255)),
                     TYP_PA ^ 64'($urandom_range(0, 255)),
                     TYP_PB ^ {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF,
                     TYP_PC ^ 16'($urandom_range(0, 255)));
         else
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
         queue_random(140);
         wait_drained();
      end

      $display("checked %0d readings over 11 calibration settings", readings_checked);
      $display("flagged invalid: %0d, temperature at a limit: %0d",
               invalid_seen, temp_clamped_seen);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
